@@ hdl/ecld_pkg.sv @@
// Shared types and constants for the encoder counter with LED display.
// No dependencies; used by ecld_digit_decode and encoder_counter_led_display.
`timescale 1ns / 1ps
`default_nettype none

package ecld_pkg;

	localparam int COUNT_W = 10;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
	localparam logic [7:0] SEG_BLANK = 8'hFF;

	// Mode bits: bit0 toggled by button one, bit1 by button two
	localparam logic [1:0] MODE_STEP1 = 2'b00;
	localparam logic [1:0] MODE_STEP2 = 2'b01;
	localparam logic [1:0] MODE_STEP4 = 2'b10;
	localparam logic [1:0] MODE_HOLD  = 2'b11;

	typedef enum logic [1:0] {
		DIR_REST = 2'd0,
		DIR_DEC  = 2'd1,
		DIR_INC  = 2'd2
	} enc_dir_t;

	typedef enum logic [2:0] {
		POS_UNITS     = 3'd0,
		POS_TENS      = 3'd1,
		POS_COLON     = 3'd2,
		POS_HUNDREDS  = 3'd3,
		POS_THOUSANDS = 3'd4
	} digit_pos_t;

	typedef struct packed {
		logic     prev_a;
		logic     step_done;
		enc_dir_t dir;
	} enc_state_t;

	typedef struct packed {
		enc_state_t           st;
		logic [COUNT_W-1:0]   cnt;
	} enc_result_t;

	// Active-low seven-segment code of one decimal digit
	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

@@ hdl/ecld_digit_decode.sv @@
// Decimal digit split and segment selection for one display position.
// Depends on ecld_pkg (digit positions, segment table).
`timescale 1ns / 1ps
`default_nettype none

module ecld_digit_decode (
	input  wire logic [9:0]           shown,     // count being displayed
	input  wire logic [6:0]           quot10,    // shown / 10
	input  wire logic [3:0]           quot100,   // shown / 100
	input  wire ecld_pkg::digit_pos_t pos,
	output logic [7:0]                seg
);

	logic [3:0] units_w;
	logic [3:0] tens_w;
	logic [3:0] hundreds_w;
	logic       thousand;

	assign thousand   = (shown >= 10'd1000);
	assign units_w    = 4'(shown - 10'(quot10) * 10'd10);
	assign tens_w     = 4'(quot10 - 7'(quot100) * 7'd10);
	assign hundreds_w = thousand ? (quot100 - 4'd10) : quot100;

	always_comb begin
		unique case (pos)
			ecld_pkg::POS_UNITS:
				seg = ecld_pkg::seg_code(units_w);
			ecld_pkg::POS_TENS:
				seg = (shown >= 10'd10) ? ecld_pkg::seg_code(tens_w)
					: ecld_pkg::SEG_BLANK;
			ecld_pkg::POS_HUNDREDS:
				seg = (shown >= 10'd100) ? ecld_pkg::seg_code(hundreds_w)
					: ecld_pkg::SEG_BLANK;
			ecld_pkg::POS_THOUSANDS:
				seg = thousand ? ecld_pkg::seg_code(4'd1) : ecld_pkg::SEG_BLANK;
			default:
				seg = ecld_pkg::SEG_BLANK;
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/encoder_counter_led_display.sv @@
// Top level: button debounce, mode bits, two quadrature encoders stepping a
// shared 10-bit count, bar graph and multiplexed seven-segment output.
// Depends on ecld_pkg and ecld_digit_decode.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: button_levels, encoder_bits
//  m_      | out | m_tvalid/m_tready  | tdata: bar, segments, count; tuser: digit
//
// Every request is one timer tick; a new one is taken every cycle unless a
// stall on m_ holds the pipeline. Stage one updates debounce, mode,
// encoder and count state and splits the shown count by 10 and 100; stage two
// picks the segment code and is the output register. A stall on m_ backs up
// through both stages, so s_tready drops only when both hold a result.
// Reset clears debounce, mode, count and position state and sets both encoders to rest.
`timescale 1ns / 1ps
`default_nettype none

module encoder_counter_led_display #(
	parameter int DEBOUNCE_SAMPLES = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [1:0] button_levels, [5:2] encoder_bits, [7:6] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [7:0] bar_pattern, [15:8] segments,
	                                    // [25:16] count_value, [31:26] zero
	output logic [2:0]       m_tuser    // [2:0] digit_select
);

	localparam int HIST_W = DEBOUNCE_SAMPLES + 1;

	// Architectural state
	logic [HIST_W-1:0]         hist0_q, hist1_q;
	logic [1:0]                mode_q;
	logic [9:0]                count_q;
	ecld_pkg::enc_state_t      enc0_q, enc1_q;
	ecld_pkg::digit_pos_t      pos_q;

	// Pipeline
	logic                      valid_s1, valid_s2;
	logic [9:0]                shown_s1, count_s1;
	logic [6:0]                quot10_s1;
	logic [3:0]                quot100_s1;
	ecld_pkg::digit_pos_t      pos_s1, pos_s2;
	logic [7:0]                bar_s1, bar_s2, seg_s2;
	logic [9:0]                count_s2;

	logic                      accept, adv_s2;
	logic [HIST_W-1:0]         hist0_n, hist1_n;
	logic                      settle0, settle1;
	logic [1:0]                mode_n;
	logic [2:0]                step_w;
	logic [7:0]                bar_w;
	ecld_pkg::enc_result_t     r0, r1;
	logic [17:0]               prod10;
	logic [15:0]               prod100;
	logic [7:0]                seg_w;

	// One encoder: latch direction on rising A, step once when A and B are high
	function automatic ecld_pkg::enc_result_t enc_step(
		input ecld_pkg::enc_state_t st,
		input logic                 a,
		input logic                 b,
		input logic [9:0]           cnt,
		input logic [2:0]           step
	);
		ecld_pkg::enc_result_t r;
		logic [10:0]           sum;
		r.st  = st;
		r.cnt = cnt;
		sum   = 11'(cnt) + 11'(step);
		if (!a || !b)
			r.st.step_done = 1'b0;
		if (!st.prev_a && a)
			r.st.dir = b ? ecld_pkg::DIR_DEC : ecld_pkg::DIR_INC;
		r.st.prev_a = a;
		if (a && b && !st.step_done) begin
			if (r.st.dir == ecld_pkg::DIR_DEC) begin
				r.cnt = (cnt < 10'(step)) ? ecld_pkg::COUNT_MAX : cnt - 10'(step);
			end else begin
				// overflow drops by 1023, so 1023 + 1 lands on 1
				if (sum > 11'(ecld_pkg::COUNT_MAX))
					sum = sum - 11'(ecld_pkg::COUNT_MAX);
				r.cnt = sum[9:0];
			end
			r.st.step_done = 1'b1;
		end
		return r;
	endfunction

	// Handshake: stage two frees when taken, stage one when it can move on
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;
	assign accept   = s_tvalid && s_tready;

	// Debounce: shift in the pin level, settled press is a lone top bit
	assign hist0_n = {hist0_q[HIST_W-2:0], s_tdata[0]};
	assign hist1_n = {hist1_q[HIST_W-2:0], s_tdata[1]};
	assign settle0 = hist0_n[HIST_W-1] && (hist0_n[HIST_W-2:0] == '0);
	assign settle1 = hist1_n[HIST_W-1] && (hist1_n[HIST_W-2:0] == '0);
	assign mode_n  = mode_q ^ {settle1, settle0};

	always_comb begin
		unique case (mode_n)
			ecld_pkg::MODE_STEP1: begin step_w = 3'd1; bar_w = 8'h01; end
			ecld_pkg::MODE_STEP2: begin step_w = 3'd2; bar_w = 8'h03; end
			ecld_pkg::MODE_STEP4: begin step_w = 3'd4; bar_w = 8'h0F; end
			default:              begin step_w = 3'd0; bar_w = 8'h00; end
		endcase
	end

	// Encoder one acts before encoder two on the same count
	assign r0 = enc_step(enc0_q, s_tdata[2], s_tdata[3], count_q, step_w);
	assign r1 = enc_step(enc1_q, s_tdata[4], s_tdata[5], r0.cnt, step_w);

	// Divide the shown count by reciprocal multiplication, exact below 1024
	assign prod10  = 18'(count_q) * 18'd205;
	assign prod100 = 16'(count_q) * 16'd41;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist0_q  <= '0;
			hist1_q  <= '0;
			mode_q   <= '0;
			count_q  <= '0;
			enc0_q   <= '{prev_a: 1'b0, step_done: 1'b1, dir: ecld_pkg::DIR_REST};
			enc1_q   <= '{prev_a: 1'b0, step_done: 1'b1, dir: ecld_pkg::DIR_REST};
			pos_q    <= ecld_pkg::POS_UNITS;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				hist0_q <= hist0_n;
				hist1_q <= hist1_n;
				mode_q  <= mode_n;
				count_q <= r1.cnt;
				enc0_q  <= r0.st;
				enc1_q  <= r1.st;
				pos_q   <= (pos_q == ecld_pkg::POS_THOUSANDS) ? ecld_pkg::POS_UNITS
					: ecld_pkg::digit_pos_t'(3'(pos_q + 3'd1));
			end
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// Payload registers: hold while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			shown_s1   <= count_q;
			quot10_s1  <= prod10[17:11];
			quot100_s1 <= prod100[15:12];
			pos_s1     <= pos_q;
			bar_s1     <= bar_w;
			count_s1   <= r1.cnt;
		end
		if (adv_s2 && valid_s1) begin
			pos_s2   <= pos_s1;
			bar_s2   <= bar_s1;
			seg_s2   <= seg_w;
			count_s2 <= count_s1;
		end
	end

	ecld_digit_decode u_digit (
		.shown   (shown_s1),
		.quot10  (quot10_s1),
		.quot100 (quot100_s1),
		.pos     (pos_s1),
		.seg     (seg_w)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, count_s2, seg_s2, bar_s2};
	assign m_tuser  = pos_s2;

endmodule

`default_nettype wire

@@ verif/ecld_checker.sv @@
// Checker for encoder_counter_led_display: watches both stream channels, runs a
// cycle-free model of the counter and display per request and compares results.
// Depends on ecld_pkg.
`timescale 1ns / 1ps

module ecld_checker #(
	parameter int DEBOUNCE_SAMPLES = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [2:0]  m_tuser,
	output int          fail_count,
	output int          pending
);

	localparam int HIST_W = DEBOUNCE_SAMPLES + 1;
	localparam int CW = ecld_pkg::COUNT_W;
	localparam logic [HIST_W-1:0] SETTLED = {1'b1, {(HIST_W-1){1'b0}}};
	localparam logic [7:0] DIGIT_SEG [10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
	};

	typedef struct {
		logic [7:0]           bar;
		ecld_pkg::digit_pos_t digit;
		logic [7:0]           seg;
		logic [CW-1:0]        cnt;
	} frame_t;

	logic [HIST_W-1:0]  hist [2];
	logic [1:0]         mode;
	logic [CW-1:0]      count;
	logic               prev_a [2];
	logic               step_done [2];
	ecld_pkg::enc_dir_t dir [2];
	logic [2:0]         pos;
	frame_t             frame_queue [$];
	frame_t             oldest;

	task automatic move_count(input int e, input logic a, input logic b,
		input logic [2:0] step);
		logic [CW:0] sum;
		if (!a || !b)
			step_done[e] = 1'b0;
		if (!prev_a[e] && a)
			dir[e] = b ? ecld_pkg::DIR_DEC : ecld_pkg::DIR_INC;
		prev_a[e] = a;
		if (a && b && !step_done[e]) begin
			if (dir[e] == ecld_pkg::DIR_DEC) begin
				count = (count < step) ? ecld_pkg::COUNT_MAX : count - step;
			end else begin
				sum = {1'b0, count} + step;
				count = (sum > ecld_pkg::COUNT_MAX) ? CW'(sum - ecld_pkg::COUNT_MAX)
					: sum[CW-1:0];
			end
			step_done[e] = 1'b1;
		end
	endtask

	task automatic run_tick(input logic [1:0] btn, input logic [3:0] enc);
		int unsigned shown;
		logic [2:0]  step;
		logic [2:0]  p;
		frame_t      f;
		shown = count;
		if (pos > 3'd4)
			pos = 3'd0;
		p = pos;
		for (int i = 0; i < 2; i++) begin
			hist[i] = {hist[i][HIST_W-2:0], btn[i]};
			if (hist[i] == SETTLED)
				mode[i] = ~mode[i];
		end
		case (mode)
			ecld_pkg::MODE_STEP1: begin step = 3'd1; f.bar = 8'h01; end
			ecld_pkg::MODE_STEP2: begin step = 3'd2; f.bar = 8'h03; end
			ecld_pkg::MODE_STEP4: begin step = 3'd4; f.bar = 8'h0F; end
			default:              begin step = 3'd0; f.bar = 8'h00; end
		endcase
		move_count(0, enc[0], enc[1], step);
		move_count(1, enc[2], enc[3], step);
		case (p)
			ecld_pkg::POS_UNITS:
				f.seg = DIGIT_SEG[shown % 10];
			ecld_pkg::POS_TENS:
				f.seg = (shown >= 10) ? DIGIT_SEG[(shown / 10) % 10] : ecld_pkg::SEG_BLANK;
			ecld_pkg::POS_HUNDREDS:
				f.seg = (shown >= 100) ? DIGIT_SEG[(shown / 100) % 10] : ecld_pkg::SEG_BLANK;
			ecld_pkg::POS_THOUSANDS:
				f.seg = (shown >= 1000) ? DIGIT_SEG[(shown / 1000) % 10]
					: ecld_pkg::SEG_BLANK;
			default:
				f.seg = ecld_pkg::SEG_BLANK;
		endcase
		pos = p + 3'd1;
		f.digit = ecld_pkg::digit_pos_t'(p);
		f.cnt = count;
		frame_queue.push_back(f);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist[0] = '0;
			hist[1] = '0;
			mode = ecld_pkg::MODE_STEP1;
			count = '0;
			prev_a[0] = 1'b0;
			prev_a[1] = 1'b0;
			step_done[0] = 1'b1;
			step_done[1] = 1'b1;
			dir[0] = ecld_pkg::DIR_REST;
			dir[1] = ecld_pkg::DIR_REST;
			pos = 3'd0;
			frame_queue.delete();
		end else begin
			if (s_tvalid && s_tready)
				run_tick(s_tdata[1:0], s_tdata[5:2]);
			if (m_tvalid && m_tready) begin
				if (frame_queue.size() == 0) begin
					$error("result with no request outstanding: tdata 0x%h tuser %0d",
						m_tdata, m_tuser);
					fail_count++;
				end else begin
					oldest = frame_queue.pop_front();
					check_field("bar_pattern", oldest.bar, m_tdata[7:0]);
					check_field("digit_select", oldest.digit, m_tuser);
					check_field("segments", oldest.seg, m_tdata[15:8]);
					check_field("count_value", oldest.cnt, m_tdata[25:16]);
				end
			end
		end
		pending = frame_queue.size();
	end

endmodule

@@ verif/tb.sv @@
// Testbench top for encoder_counter_led_display: drives ticks with random gaps
// and output stalls, and reports the verdict from ecld_checker.
// Depends on ecld_pkg, ecld_checker and the block itself.
`timescale 1ns / 1ps

module tb;

	localparam int LIMIT = 200000;
	localparam int RANDOM_TICKS = 800;
	// Quadrature phases as {B, A}; the last phase lands on both-high and steps
	localparam logic [1:0] INC_SEQ [4] = '{2'b10, 2'b00, 2'b01, 2'b11};
	localparam logic [1:0] DEC_SEQ [4] = '{2'b01, 2'b00, 2'b10, 2'b11};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	int          n_fail;
	int          n_pending;
	int          n_sent = 0;
	bit          src_idle = 1'b1;
	bit          snk_idle = 1'b1;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	encoder_counter_led_display u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	ecld_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (n_fail),
		.pending    (n_pending)
	);

	// Offer one tick request; hold valid high across back-to-back requests so it
	// is never dropped and raised in the same step.
	task automatic send_tick(input logic [1:0] btn, input logic [3:0] enc);
		int gap;
		gap = src_idle ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, enc, btn};
		do @(posedge clk); while (!s_tready);
		n_sent++;
	endtask

	// Walk zero, one or both encoders through a full detent. Each encoder picks
	// increment, decrement or rest; phases may bounce by repeating.
	task automatic turn_detent();
		int         how1, how2, reps;
		logic [1:0] ph1, ph2, btn;
		how1 = $urandom_range(0, 2);
		how2 = $urandom_range(0, 2);
		btn = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'b11;
		for (int k = 0; k < 4; k++) begin
			ph1 = (how1 == 1) ? INC_SEQ[k] : (how1 == 2) ? DEC_SEQ[k] : 2'b11;
			ph2 = (how2 == 1) ? INC_SEQ[k] : (how2 == 2) ? DEC_SEQ[k] : 2'b11;
			reps = ($urandom_range(0, 4) == 0) ? 2 : 1;
			repeat (reps) send_tick(btn, {ph2, ph1});
		end
	endtask

	// Hold one or both buttons low; twelve or more ticks settle a press, fewer
	// is a bounce. Release afterwards so the next press can settle too.
	task automatic press_buttons();
		logic [1:0] held;
		int         len;
		held = 2'($urandom_range(1, 3));
		len = $urandom_range(8, 16);
		repeat (len)
			send_tick(~held, ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'hF);
		send_tick(2'b11, 4'hF);
	endtask

	// Drain results: random hold-offs, stretches without them, and one long
	// stall that backs up the pipeline and must drop s_tready.
	initial begin
		int gap;
		int nres;
		nres = 0;
		@(posedge arst_n);
		forever begin
			gap = snk_idle ? $urandom_range(0, 9) : 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			nres++;
			if (nres % 100 == 0)
				snk_idle = ($urandom_range(0, 2) != 0);
			if (nres == 300) begin
				m_tready <= 1'b0;
				repeat (80) @(posedge clk);
			end
		end
	end

	// Watchdog: give up long after the slowest legal run
	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("tb failed");
		$finish;
	end

	initial begin
		int pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: seed the button history with a release, then underflow
		// from zero, overflow past the top, encoder two alone, both encoders
		// stepping on the same tick, and raw button and encoder extremes.
		send_tick(2'b11, 4'hF);
		for (int k = 0; k < 4; k++) send_tick(2'b11, {2'b11, DEC_SEQ[k]});
		for (int k = 0; k < 4; k++) send_tick(2'b11, {2'b11, INC_SEQ[k]});
		for (int k = 0; k < 4; k++) send_tick(2'b11, {DEC_SEQ[k], 2'b11});
		send_tick(2'b11, 4'h0);
		send_tick(2'b11, 4'hF);
		send_tick(2'b00, 4'b0101);
		send_tick(2'b01, 4'b1010);
		send_tick(2'b10, 4'hF);
		send_tick(2'b11, 4'hF);

		// Random: mostly clean detents and button presses, some noise
		while (n_sent < RANDOM_TICKS + 20) begin
			if ($urandom_range(0, 15) == 0)
				src_idle = !src_idle;
			pick = $urandom_range(0, 99);
			if (pick < 60)
				turn_detent();
			else if (pick < 82)
				press_buttons();
			else
				repeat ($urandom_range(1, 4)) send_tick(2'($urandom), 4'($urandom));
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (n_pending == 0);
		repeat (4) @(posedge clk);
		if (n_fail == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
